// ===== hdl/segt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segt_pkg : shared types and constants for the segment tree range sum block
// Field widths, default capacity, operation codes, reset value of the element count
// and the sequencer state type.
// ----------------------------------------------------------------------------
package segt_pkg;

   // fixed field widths
   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;
   localparam int DATA_W  = 32;

   // default capacity of the tree
   localparam int MAX_ELEMENTS_DEFAULT = 64;

   // element count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_READ,
      ST_LD_WRITE,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_OUT
   } segt_state_type;

endpackage : segt_pkg
`default_nettype wire

// ===== hdl/segt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segt_ctrl : tree store, shared adder and sequencer
// Holds the partial sums in a one-write, one-read memory. Loads walk the
// leaf-to-root path, queries walk the tree bottom-up; one adder serves both.
// ----------------------------------------------------------------------------
module segt_ctrl #(
   parameter int MAX_ELEMENTS = segt_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_operation,
   input  wire logic [segt_pkg::INDEX_W-1:0]      req_element_index,
   input  wire logic signed [segt_pkg::DATA_W-1:0] req_element_value,
   input  wire logic [segt_pkg::INDEX_W-1:0]      req_range_start,
   input  wire logic [segt_pkg::INDEX_W-1:0]      req_range_end,
   input  wire logic [segt_pkg::COUNT_W-1:0]      element_count,
   output logic                                   res_valid,
   input  wire logic                              res_ready,
   output logic [segt_pkg::DATA_W-1:0]            res_sum
);
   import segt_pkg::*;

   localparam int DEPTH = 2 * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = AW + 1;
   localparam int CNT_W = (NW > COUNT_W) ? NW : COUNT_W;

   // tree store
   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   segt_state_type    state_ff, state_in;
   logic [NW-1:0]     node_ff, node_in;     // load path node, or left bound
   logic [NW-1:0]     right_ff, right_in;   // right bound (exclusive)
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;     // read data due for the adder
   logic [AW-1:0]     clr_ff, clr_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;

   logic [DATA_W-1:0] sum;
   logic [CNT_W-1:0]  eff_cnt;
   logic [CNT_W-1:0]  rs_ext;
   logic [CNT_W-1:0]  re_ext;
   logic [CNT_W-1:0]  last;
   logic              ld_ok;
   logic              q_ok;
   logic [NW-1:0]     leaf;
   logic [NW-1:0]     q_left;
   logic [NW-1:0]     q_right;
   logic              span_left;
   logic [NW-1:0]     node_up;
   logic [NW-1:0]     right_dec;

   // shared adder: accumulator plus pending read
   assign sum = acc_ff + (pend_ff ? rd_data_ff : '0);

   // clip count to capacity and decode the item
   assign eff_cnt = (CNT_W'(element_count) > CNT_W'(MAX_ELEMENTS)) ?
                    CNT_W'(MAX_ELEMENTS) : CNT_W'(element_count);
   assign rs_ext  = CNT_W'(req_range_start);
   assign re_ext  = CNT_W'(req_range_end);
   assign last    = (re_ext < eff_cnt - CNT_W'(1)) ? re_ext : eff_cnt - CNT_W'(1);
   assign ld_ok   = CNT_W'(req_element_index) < eff_cnt;
   assign q_ok    = (eff_cnt != '0) && (rs_ext < eff_cnt) && (rs_ext <= last);
   assign leaf    = NW'(MAX_ELEMENTS) + NW'(req_element_index);
   assign q_left  = NW'(MAX_ELEMENTS) + NW'(rs_ext);
   assign q_right = NW'(MAX_ELEMENTS) + NW'(last) + NW'(1);

   assign span_left = node_ff < right_ff;
   assign node_up   = node_ff >> 1;
   assign right_dec = right_ff - NW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_QUERY) state_in = ST_Q_LEFT;
               else if (ld_ok)                state_in = ST_LD_READ;
            end
         end
         ST_LD_READ: begin
            state_in = (node_ff == NW'(1)) ? ST_IDLE : ST_LD_WRITE;
         end
         ST_LD_WRITE: state_in = ST_LD_READ;
         ST_Q_LEFT: begin
            state_in = span_left ? ST_Q_RIGHT : ST_OUT;
         end
         ST_Q_RIGHT: state_in = ST_Q_LEFT;
         ST_OUT: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and memory ports
   always_comb begin
      node_in   = node_ff;
      right_in  = right_ff;
      acc_in    = acc_ff;
      pend_in   = 1'b0;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      mem_waddr = node_up[AW-1:0];
      mem_wdata = sum;
      mem_raddr = node_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_LOAD) begin
                  // write the leaf and start the path from it
                  if (ld_ok) begin
                     mem_we    = 1'b1;
                     mem_waddr = leaf[AW-1:0];
                     mem_wdata = req_element_value;
                     acc_in    = req_element_value;
                     node_in   = leaf;
                  end
               end else begin
                  // an empty range runs zero steps and gives 0
                  acc_in   = '0;
                  node_in  = q_ok ? q_left  : '0;
                  right_in = q_ok ? q_right : '0;
               end
            end
         end
         ST_LD_READ: begin
            // fetch the sibling of the current node
            mem_raddr = node_ff[AW-1:0] ^ AW'(1);
            pend_in   = 1'b1;
         end
         ST_LD_WRITE: begin
            // parent takes child plus sibling
            mem_we  = 1'b1;
            acc_in  = sum;
            node_in = node_up;
         end
         ST_Q_LEFT: begin
            acc_in = sum;
            if (span_left && node_ff[0]) begin
               mem_raddr = node_ff[AW-1:0];
               node_in   = node_ff + NW'(1);
               pend_in   = 1'b1;
            end
         end
         ST_Q_RIGHT: begin
            acc_in = sum;
            if (right_ff[0]) begin
               mem_raddr = right_dec[AW-1:0];
               pend_in   = 1'b1;
            end
            node_in  = node_up;
            right_in = right_ff >> 1;
         end
         ST_OUT: begin
            acc_in = acc_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_OUT);
   assign res_sum   = acc_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      right_ff <= right_in;
      acc_ff   <= acc_in;
   end

   // tree store: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule : segt_ctrl
`default_nettype wire

// ===== hdl/segment_tree_range_sum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segment_tree_range_sum : segment tree of signed 32-bit partial sums
// Loads write one element and refresh the sums up to the root; queries return
// the wrapped sum over an inclusive index range clipped to the element count.
//
//   channel   prefix   direction   contents
//   request   req_     in          operation, element index/value, range
//   response  rsp_     out         range_sum, one per query
//   control   csr_     in          element_count write data
//
// A load writes its leaf, then takes a sibling read and a parent write per
// tree level on the way to the root before the next request is taken.
// A query walks the tree bottom-up with a left and a right step per level.
// After reset a clearing pass zeroes every word of the tree.
// Reset is synchronous and active high; no request is taken until cleared.
// A held response stalls the finish of the next query, not its transfer.
// ----------------------------------------------------------------------------
module segment_tree_range_sum #(
   parameter int MAX_ELEMENTS = segt_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_operation,
   input  wire logic [segt_pkg::INDEX_W-1:0]       req_element_index,
   input  wire logic signed [segt_pkg::DATA_W-1:0] req_element_value,
   input  wire logic [segt_pkg::INDEX_W-1:0]       req_range_start,
   input  wire logic [segt_pkg::INDEX_W-1:0]       req_range_end,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [segt_pkg::DATA_W-1:0]      rsp_range_sum,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [segt_pkg::COUNT_W-1:0]       csr_element_count
);
   import segt_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic               res_valid;
   logic               res_ready;
   logic [DATA_W-1:0]  res_sum;

   segt_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .element_count     (count_ff),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res_sum           (res_sum)
   );

   // element count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         count_ff <= csr_element_count;
      end
   end

   // output register: free when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_sum_in = res_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

endmodule : segment_tree_range_sum
`default_nettype wire

// ===== tb/tb_segment_tree_range_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_tree_range_sum : self-checking bench for the range sum block
// Loads and range queries go in through the request channel in random bursts.
// A behavioural tree of partial sums in the bench predicts each query result,
// which is checked against the response channel while the receiver stalls on
// its own pattern. The element count is rewritten between phases, covering
// zero, one, the capacity and values above it.
// ----------------------------------------------------------------------------
module tb_segment_tree_range_sum;
   import segt_pkg::*;

   localparam int LEAVES = MAX_ELEMENTS_DEFAULT;
   // a load walks the whole path to the root; allow it to finish
   localparam int SETTLE_CYCLES = 24;

   typedef struct {
      logic                     op;
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] value;
      logic [INDEX_W-1:0]       first;
      logic [INDEX_W-1:0]       last;
   } tree_request_type;

   typedef enum {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_operation = OP_LOAD;
   logic [INDEX_W-1:0]       req_element_index = '0;
   logic signed [DATA_W-1:0] req_element_value = '0;
   logic [INDEX_W-1:0]       req_range_start = '0;
   logic [INDEX_W-1:0]       req_range_end = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_range_sum;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [COUNT_W-1:0]       csr_element_count = '0;

   // bench-side copy of the tree and the count register
   logic [DATA_W-1:0]  partial_sums [0:2*LEAVES-1];
   logic [COUNT_W-1:0] active_count = COUNT_RESET;
   logic [COUNT_W-1:0] phase_count = COUNT_RESET;

   tree_request_type   pending_requests [$];
   logic [DATA_W-1:0]  expected_sums [$];
   int                 items_queued = 0;
   int                 items_accepted = 0;
   int                 mismatch_count = 0;
   logic               req_xfer = 1'b0;
   int                 burst_left = 1;
   int                 gap_left = 0;
   rx_mode_type        rx_mode = RX_ALWAYS;
   int                 rx_mode_left = 0;

   segment_tree_range_sum u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_range_sum     (rsp_range_sum),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic int usable_count(input logic [COUNT_W-1:0] setting);
      int c;
      c = int'(setting);
      return (c > LEAVES) ? LEAVES : c;
   endfunction

   // write one leaf, then rebuild the sums on its path to the root
   function automatic void tree_store(input logic [INDEX_W-1:0] index,
                                      input logic [DATA_W-1:0] value);
      int node;
      if (int'(index) >= usable_count(active_count)) return;
      node = LEAVES + int'(index);
      partial_sums[node] = value;
      while (node > 1) begin
         node = node >> 1;
         partial_sums[node] = partial_sums[2*node] + partial_sums[2*node+1];
      end
   endfunction

   // inclusive range, end clipped to the count; empty ranges sum to zero
   function automatic logic [DATA_W-1:0] tree_range_sum(input logic [INDEX_W-1:0] first,
                                                        input logic [INDEX_W-1:0] last);
      int               cnt;
      int               stop;
      int               lo;
      int               hi;
      logic [DATA_W-1:0] acc;
      cnt = usable_count(active_count);
      acc = '0;
      if (cnt == 0 || int'(first) >= cnt) return acc;
      stop = (int'(last) < cnt - 1) ? int'(last) : cnt - 1;
      if (int'(first) > stop) return acc;
      lo = int'(first) + LEAVES;
      hi = stop + 1 + LEAVES;
      while (lo < hi) begin
         if (lo[0]) begin
            acc = acc + partial_sums[lo];
            lo = lo + 1;
         end
         if (hi[0]) begin
            hi = hi - 1;
            acc = acc + partial_sums[hi];
         end
         lo = lo >> 1;
         hi = hi >> 1;
      end
      return acc;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic tree_request_type make_load(input int index,
                                                  input logic [DATA_W-1:0] value);
      tree_request_type r;
      r.op    = OP_LOAD;
      r.index = INDEX_W'(index);
      r.value = value;
      r.first = INDEX_W'($urandom);
      r.last  = INDEX_W'($urandom);
      return r;
   endfunction

   function automatic tree_request_type make_query(input int first, input int last);
      tree_request_type r;
      r.op    = OP_QUERY;
      r.index = INDEX_W'($urandom);
      r.value = $urandom;
      r.first = INDEX_W'(first);
      r.last  = INDEX_W'(last);
      return r;
   endfunction

   // mostly in-range traffic, with some indices anywhere in the field
   function automatic tree_request_type random_request(input logic [COUNT_W-1:0] setting);
      int               cnt;
      int               first;
      int               last;
      logic [DATA_W-1:0] value;
      cnt = usable_count(setting);
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 7))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = DATA_W'($urandom_range(0, 200) - 100);
            default: value = $urandom;
         endcase
         if (cnt > 0 && $urandom_range(0, 9) != 0)
            return make_load($urandom_range(0, cnt - 1), value);
         return make_load($urandom_range(0, LEAVES - 1), value);
      end
      if (cnt > 0 && $urandom_range(0, 9) < 8) begin
         first = $urandom_range(0, cnt - 1);
         if ($urandom_range(0, 4) == 0)
            last = $urandom_range(0, LEAVES - 1);
         else
            last = $urandom_range(first, cnt - 1);
         return make_query(first, last);
      end
      return make_query($urandom_range(0, LEAVES - 1), $urandom_range(0, LEAVES - 1));
   endfunction

   task automatic queue_request(input tree_request_type r);
      pending_requests.push_back(r);
      items_queued++;
   endtask

   task automatic queue_random(input int n);
      repeat (n) queue_request(random_request(phase_count));
   endtask

   // hold until every transfer is done and the last load has finished
   task automatic settle();
      while (items_accepted != items_queued || expected_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] setting);
      settle();
      @(negedge clock);
      csr_element_count <= setting;
      csr_valid         <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid   <= 1'b0;
      phase_count = setting;
   endtask

   task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s: expected %0d (0x%08h), got %0d (0x%08h)", $time, what,
                  $signed(want), want, $signed(got), got);
   endtask

   // ------------------------------------------------------------------------
   // request driver: bursts of random length with gaps between them
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      tree_request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_operation     <= r.op;
            req_element_index <= r.index;
            req_element_value <= r.value;
            req_range_start   <= r.first;
            req_range_end     <= r.last;
            req_valid         <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(40, 160);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 8);
                  gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25)
                                                           : $urandom_range(0, 4);
               end
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response stall pattern: a mode held for a random stretch of cycles
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left = rx_mode_left - 1;
      case (rx_mode)
         RX_ALWAYS: rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // monitor: track count writes, predict on request transfers, check results
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      req_xfer = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready)
            active_count = csr_element_count;
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               note_mismatch("range_sum with none expected", '0, rsp_range_sum);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_range_sum !== want)
                  note_mismatch("range_sum", want, rsp_range_sum);
            end
         end
         if (req_valid && req_ready) begin
            req_xfer = 1'b1;
            items_accepted++;
            if (req_operation == OP_LOAD)
               tree_store(req_element_index, req_element_value);
            else
               expected_sums.push_back(tree_range_sum(req_range_start, req_range_end));
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequence of phases
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < 2*LEAVES; i++) partial_sums[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes, wrap-around and empty ranges at the reset count
      queue_request(make_load(0, 32'h7FFF_FFFF));
      queue_request(make_load(63, 32'h8000_0000));
      queue_request(make_load(42, 32'hFFFF_FFFF));
      queue_request(make_load(21, 32'h0000_0001));
      queue_request(make_query(0, 63));
      queue_request(make_query(0, 0));
      queue_request(make_query(63, 63));
      queue_request(make_query(21, 42));
      queue_request(make_query(42, 21));
      queue_request(make_load(1, 32'h7FFF_FFFF));
      queue_request(make_query(0, 1));
      queue_request(make_load(0, 32'h0000_0000));
      queue_request(make_query(0, 63));
      queue_request(make_query(5, 5));
      queue_random(250);

      // count above capacity acts as full capacity
      write_count(7'd127);
      queue_request(make_query(0, 63));
      queue_random(100);

      // count lowered: loads past it dropped, ranges clipped
      write_count(7'd37);
      queue_request(make_load(40, 32'h1234_5678));
      queue_request(make_query(30, 63));
      queue_request(make_query(37, 40));
      queue_request(make_query(36, 36));
      queue_random(150);

      // zero count: loads ignored, every query gives zero
      write_count(7'd0);
      queue_request(make_load(0, 32'h0000_0055));
      queue_request(make_query(0, 63));
      queue_random(30);

      // single element
      write_count(7'd1);
      queue_request(make_query(0, 63));
      queue_request(make_load(0, 32'h8000_0000));
      queue_request(make_query(0, 0));
      queue_request(make_query(1, 1));
      queue_random(60);

      // back to full: elements above the old count reappear
      write_count(7'd64);
      queue_request(make_query(37, 63));
      queue_random(150);

      write_count(7'd2);
      queue_random(60);

      write_count(7'd85);
      queue_random(40);

      write_count(7'd42);
      queue_random(40);

      settle();
      if (mismatch_count == 0 && expected_sums.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
